### src/uart_text_command_value_parser_unit_assert.svh
// assertion macros shared by the parser rtl files
// expects clk and rst_n in the scope of every use
`ifndef UART_TEXT_COMMAND_VALUE_PARSER_UNIT_ASSERT_SVH
`define UART_TEXT_COMMAND_VALUE_PARSER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define UTCV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define UTCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/utcv_pkg.sv
// shared constants, prefix table and result type for the text command parser
// no dependencies
`default_nettype none

package utcv_pkg;

    // line length limit and derived position width
    localparam int LINE_MAX = 128;
    localparam int POS_W    = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

    localparam int NUM_TARGETS = 6;

    // byte codes
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // prefix text per target, padded with zero bytes
    localparam logic [7:0] PREFIX_TEXT [NUM_TARGETS][8] = '{
        '{"B", "P", "M", ":", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"T", "E", "M", "P", ":",  8'd0, 8'd0, 8'd0},
        '{"H", "U", "M", ":", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"P", "R", "E", "S", ":",  8'd0, 8'd0, 8'd0},
        '{"L", "G", "T", ":", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"A", "C", "C", "Z", ":",  8'd0, 8'd0, 8'd0}
    };

    localparam logic [2:0] PREFIX_LEN [NUM_TARGETS] = '{
        3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd5
    };

    // one parsed line outcome
    typedef struct packed {
        logic        hit;
        logic [2:0]  target;
        logic [31:0] value;
    } utcv_result_t;

endpackage

`default_nettype wire

### src/utcv_line_parser.sv
// per-byte line parser: prefix match and atoi style number accumulate
// depends on utcv_pkg and the assertion macro header
`default_nettype none
`include "uart_text_command_value_parser_unit_assert.svh"

module utcv_line_parser
    import utcv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire logic [7:0]   rx_byte,
    output utcv_result_t      result
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    logic [POS_W-1:0]       pos_reg,   pos_next;
    logic [NUM_TARGETS-1:0] cand_reg,  cand_next;
    phase_t                 phase_reg, phase_next;
    logic                   neg_reg,   neg_next;
    logic [31:0]            acc_reg,   acc_next;

    logic                   is_term;
    logic                   is_digit;
    logic                   is_space;
    logic [NUM_TARGETS-1:0] past_prefix;
    logic                   feed;

    // byte classes
    assign is_term  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_space = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                      (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);

    // which prefixes are already fully matched at this position
    always_comb
    begin
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            past_prefix[i] = pos_reg >= POS_W'(PREFIX_LEN[i]);
        end
    end

    // only one candidate can survive the first byte, so the number feeds once
    assign feed = |(cand_reg & past_prefix);

    // result on a terminator: first surviving candidate past its prefix
    always_comb
    begin
        result.hit    = 1'b0;
        result.target = 3'd0;
        result.value  = neg_reg ? (32'd0 - acc_reg) : acc_reg;
        if (is_term && (pos_reg != '0))
        begin
            for (int i = NUM_TARGETS - 1; i >= 0; i--)
            begin
                if (cand_reg[i] && past_prefix[i])
                begin
                    result.hit    = 1'b1;
                    result.target = 3'(i);
                end
            end
        end
    end

    // next line state
    always_comb
    begin
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (is_term)
        begin
            pos_next   = '0;
            cand_next  = '1;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
        else if (pos_reg < POS_LAST)
        begin
            pos_next = pos_reg + POS_W'(1);
            // prefix compare for candidates still inside their prefix
            for (int i = 0; i < NUM_TARGETS; i++)
            begin
                if (cand_reg[i] && !past_prefix[i] &&
                    (rx_byte != PREFIX_TEXT[i][pos_reg[2:0]]))
                begin
                    cand_next[i] = 1'b0;
                end
            end
            // number phase step
            if (feed)
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (is_space)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS))
                        begin
                            neg_next   = (rx_byte == CHAR_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else
                        begin
                            phase_next = is_digit ? PH_DIGITS : PH_DONE;
                        end
                    end
                    PH_SIGN:
                    begin
                        phase_next = is_digit ? PH_DIGITS : PH_DONE;
                    end
                    PH_DIGITS:
                    begin
                        phase_next = is_digit ? PH_DIGITS : PH_DONE;
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
                // times ten plus digit, wrapping
                if (is_digit && (phase_next == PH_DIGITS))
                begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + {28'd0, rx_byte[3:0]};
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            cand_reg  <= '1;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    // position never passes the last kept byte
    `UTCV_ASSERT_SAME(a_pos_range, 1'b1, pos_reg <= POS_LAST, "line position out of range")
    // prefixes differ in their first byte, so at most one survives
    `UTCV_ASSERT_SAME(a_cand_single, pos_reg != '0, $onehot0(cand_reg),
        "more than one prefix candidate after first byte")
    // the number parser only leaves skip once a prefix is matched
    `UTCV_ASSERT_SAME(a_phase_needs_prefix, phase_reg != PH_SKIP, feed || is_term || !take,
        "number phase active without matched prefix")

endmodule

`default_nettype wire

### src/uart_text_command_value_parser_unit.sv
// top level of the uart text command value parser
// depends on utcv_pkg, utcv_line_parser and the assertion macro header
//
//  channel   signals                        direction  payload
//  -------   ----------------------------   ---------  --------------------------
//  input     in_valid, in_ready, rx_byte    in         one received byte
//  output    out_valid, out_ready, target,  out        loaded target and value
//            new_value
//
// one byte per cycle sustained while out_ready is high; a result follows its terminator
// byte through the input register, then the parse into the result register
// the output register holds a result while out_ready is low; the input register
// keeps taking bytes until it is full and the output register is stalled
// reset clears the line state; no clearing pass is needed
`default_nettype none
`include "uart_text_command_value_parser_unit_assert.svh"

module uart_text_command_value_parser_unit
    import utcv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              target,
    output logic signed [31:0]      new_value
);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_target_reg;
    logic signed [31:0] out_value_reg;
    logic               advance;
    logic               take;
    utcv_result_t       result;

    // handshake control
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign take     = s1_valid_reg && advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    utcv_line_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (s1_byte_reg),
        .result  (result)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = result.hit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && result.hit)
        begin
            out_target_reg <= result.target;
            out_value_reg  <= signed'(result.value);
        end
    end

    assign out_valid = out_valid_reg;
    assign target    = out_target_reg;
    assign new_value = out_value_reg;

    // a result only comes from a byte sitting in the input register
    `UTCV_ASSERT_NEXT(a_no_phantom, !out_valid_reg && !s1_valid_reg, !out_valid_reg,
        "result transaction without a pending byte")
    // a stalled input register keeps its byte
    `UTCV_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_byte_reg), "stalled input byte lost")
    // target code names one of the six stored values
    `UTCV_ASSERT_SAME(a_target_range, out_valid_reg, out_target_reg <= 3'(NUM_TARGETS - 1),
        "target code out of range")

endmodule

`default_nettype wire

### bench/utcv_load_checker.sv
// load checker for the uart text command value parser: predicts loads from accepted bytes
// and compares them with the results on the output channel
// depends on utcv_pkg for the byte codes and the line length limit
`timescale 1ns / 100ps

module utcv_load_checker
    import utcv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         target,
    input  logic signed [31:0] new_value,
    output int                 mismatches,
    output int                 pending
);

    typedef enum logic [2:0] {
        TGT_BPM,
        TGT_TEMP,
        TGT_HUM,
        TGT_PRES,
        TGT_LGT,
        TGT_ACCZ
    } target_e;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_SIGNED,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_e;

    typedef struct packed {
        logic [2:0]  target;
        logic [31:0] value;
    } load_t;

    // line state of the predictor
    int unsigned line_len;
    logic [5:0]  live;
    num_phase_e  phase;
    logic        minus;
    logic [31:0] acc;

    // loads predicted but not yet seen on the output
    load_t loads_due[$];

    function automatic string command_word(input int t);
        case (target_e'(t))
            TGT_BPM:  return "BPM:";
            TGT_TEMP: return "TEMP:";
            TGT_HUM:  return "HUM:";
            TGT_PRES: return "PRES:";
            TGT_LGT:  return "LGT:";
            default:  return "ACCZ:";
        endcase
    endfunction

    function void clear_line();
        line_len = 0;
        live     = '1;
        phase    = NUM_SKIP;
        minus    = 1'b0;
        acc      = '0;
    endfunction

    // atoi style number scan, one byte after the prefix
    function void number_byte(input logic [7:0] b);
        logic is_digit;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        if (phase == NUM_SKIP) begin
            if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_VT || b == CHAR_FF)
                return;
            if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                minus = (b == CHAR_MINUS);
                phase = NUM_SIGNED;
                return;
            end
            phase = is_digit ? NUM_DIGITS : NUM_DONE;
        end
        else if (phase == NUM_SIGNED) begin
            phase = is_digit ? NUM_DIGITS : NUM_DONE;
        end
        else if (phase == NUM_DIGITS && !is_digit) begin
            phase = NUM_DONE;
        end
        if (phase == NUM_DIGITS)
            acc = acc * 32'd10 + {24'd0, b - CHAR_ZERO};
    endfunction

    function void predict_rx_byte(input logic [7:0] b);
        string word;
        load_t ld;
        bit    found;
        found = 1'b0;
        if (b == CHAR_LF || b == CHAR_CR) begin
            // terminator: first surviving prefix that was seen whole loads the value
            if (line_len != 0) begin
                for (int t = 0; t < 6; t++) begin
                    word = command_word(t);
                    if (!found && live[t] && line_len >= word.len()) begin
                        found     = 1'b1;
                        ld.target = 3'(t);
                        ld.value  = minus ? (32'd0 - acc) : acc;
                        loads_due.push_back(ld);
                    end
                end
            end
            clear_line();
        end
        else if (line_len < LINE_MAX - 1) begin
            // prefix match, then the number scan once a prefix is complete
            for (int t = 0; t < 6; t++) begin
                word = command_word(t);
                if (live[t]) begin
                    if (line_len < word.len()) begin
                        if (b != word[line_len])
                            live[t] = 1'b0;
                    end
                    else begin
                        number_byte(b);
                    end
                end
            end
            line_len++;
        end
    endfunction

    // watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        load_t due;
        if (!rst_n) begin
            clear_line();
            loads_due.delete();
        end
        else begin
            if (in_valid && in_ready)
                predict_rx_byte(rx_byte);
            if (out_valid && out_ready) begin
                if (loads_due.size() == 0) begin
                    $display("%0t: unexpected transaction: target %0d value %0d",
                             $time, target, new_value);
                    mismatches++;
                end
                else begin
                    due = loads_due.pop_front();
                    if (target !== due.target) begin
                        $display("%0t: target mismatch: expected %0d actual %0d",
                                 $time, due.target, target);
                        mismatches++;
                    end
                    if (new_value !== due.value) begin
                        $display("%0t: new_value mismatch: expected %0d actual %0d",
                                 $time, $signed(due.value), new_value);
                        mismatches++;
                    end
                end
            end
        end
        pending <= loads_due.size();
    end

endmodule

### bench/uart_text_command_value_parser_unit_tb.sv
// testbench top for the uart text command value parser: sends text lines, stalls the
// output side at random and gives the verdict
// depends on utcv_pkg, the parser rtl and utcv_load_checker
`timescale 1ns / 100ps

module uart_text_command_value_parser_unit_tb;

    import utcv_pkg::*;

    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int TAIL_CYCLES     = 8;
    localparam int NOISY_BYTES     = 1400;
    localparam int TOTAL_BYTES     = 1600;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         target;
    logic signed [31:0] new_value;

    int mismatches;
    int pending;
    int bytes_sent = 0;
    bit steady = 1'b0;
    // count of long hold-offs requested by the stimulus
    int hold_off_req = 0;

    uart_text_command_value_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .target    (target),
        .new_value (new_value)
    );

    utcv_load_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .target     (target),
        .new_value  (new_value),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one byte transaction, with an optional idle burst in front
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!steady && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    // mostly well formed commands with random numbers, the rest noise, broken, empty and overlong lines
    task automatic send_random_line();
        logic [7:0] text[$];
        int kind;
        int t;
        int n;
        int pos;
        kind = $urandom_range(0, 99);
        t    = $urandom_range(0, NUM_TARGETS - 1);
        if (kind < 92 && kind >= 70 && kind < 80) begin
            // pure noise, any byte value
            n = $urandom_range(0, 12);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 92) begin
            for (int k = 0; k < PREFIX_LEN[t]; k++)
                text.push_back(PREFIX_TEXT[t][k]);
            // broken prefix: one byte corrupted, sometimes cut short
            if (kind >= 80) begin
                pos = $urandom_range(0, PREFIX_LEN[t] - 1);
                text[pos] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    while (text.size() > pos + 1)
                        void'(text.pop_back());
            end
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) text.push_back(blank_byte());
            end
            case ($urandom_range(0, 3))
                0:       text.push_back(CHAR_PLUS);
                1:       text.push_back(CHAR_MINUS);
                default: ;
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
            repeat (n) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0)
                text.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 99) begin
            // overlong line, tail past the limit is dropped
            for (int k = 0; k < PREFIX_LEN[t]; k++)
                text.push_back(PREFIX_TEXT[t][k]);
            n = $urandom_range(120, 135);
            repeat (n) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        // otherwise an empty line
        text.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
        foreach (text[i])
            send_byte(text[i]);
    endtask

    // main stimulus
    initial
    begin
        bit second_hold_done;
        second_hold_done = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines: every target, value extremes and the corner cases
        send_text("BPM:72");
        send_byte(CHAR_LF);
        send_text("TEMP:");
        send_byte(CHAR_SPACE);
        send_byte(CHAR_TAB);
        send_byte(CHAR_VT);
        send_byte(CHAR_FF);
        send_text("-37");
        send_byte(CHAR_CR);
        send_text("HUM:+2147483647");
        send_byte(CHAR_LF);
        send_text("PRES:-2147483648");
        send_byte(CHAR_LF);
        send_text("LGT:4294967295");
        send_byte(CHAR_CR);
        send_text("ACCZ:99999999999999999999");
        send_byte(CHAR_LF);
        // lone sign and prefix without digits load zero
        send_text("HUM:-");
        send_byte(CHAR_LF);
        send_text("LGT:");
        send_byte(CHAR_CR);
        // zero byte ends the number
        send_text("BPM:12");
        send_byte(8'h00);
        send_text("34");
        send_byte(CHAR_LF);
        // zero byte inside the prefix, unknown prefix, partial prefix
        send_text("BP");
        send_byte(8'h00);
        send_text("M:5");
        send_byte(CHAR_LF);
        send_text("XYZ:5");
        send_byte(CHAR_LF);
        send_text("BPM");
        send_byte(CHAR_LF);
        // empty lines
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // all-ones byte ends the number
        send_text("ACCZ:");
        send_byte(8'hFF);
        send_text("9");
        send_byte(CHAR_LF);
        send_text("TEMP:  00042xyz");
        send_byte(CHAR_CR);
        // long line
        send_text("PRES:");
        repeat (140) send_byte("7");
        send_byte(CHAR_LF);

        // random part, with a long output hold-off at its start and midway
        hold_off_req = hold_off_req + 1;
        while (bytes_sent < NOISY_BYTES) begin
            if (!second_hold_done && bytes_sent > NOISY_BYTES / 2) begin
                second_hold_done = 1'b1;
                hold_off_req = hold_off_req + 1;
            end
            send_random_line();
        end
        steady = 1'b1;
        while (bytes_sent < TOTAL_BYTES)
            send_random_line();
        in_valid <= 1'b0;

        // drain
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: short random stalls, and a long hold-off when asked
    initial
    begin : receiver
        int stall;
        int holds_done;
        holds_done = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (holds_done < hold_off_req) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!steady && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 4);
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
